@@ rtl/lctf_pkg.sv @@
// lctf_pkg: shared types, register codes and arithmetic helpers for the
// layered color tint filter. No dependencies.
package lctf_pkg;

  localparam int unsigned AddrW = 5;
  localparam int unsigned DataW = 32;

  // register indexes (paddr[4:2])
  localparam logic [2:0] REG_FIRST_ENABLE  = 3'd0;
  localparam logic [2:0] REG_FIRST_COLOR   = 3'd1;
  localparam logic [2:0] REG_FIRST_LEVEL   = 3'd2;
  localparam logic [2:0] REG_SECOND_ENABLE = 3'd3;
  localparam logic [2:0] REG_SECOND_COLOR  = 3'd4;
  localparam logic [2:0] REG_SECOND_LEVEL  = 3'd5;

  localparam logic [7:0] ALPHA_FULL = 8'd250;
  localparam logic [7:0] BLEND_ONE  = 8'd128;
  localparam logic [6:0] LEVEL_MAX  = 7'd100;

  // one pipeline word: pixel plus both layer strengths
  typedef struct packed {
    logic [31:0] pixel;
    logic [6:0]  s1;
    logic [6:0]  s2;
  } lctf_word_t;

  // one tint layer as programmed
  typedef struct packed {
    logic        enable;
    logic [23:0] color;
    logic [6:0]  level;
  } lctf_layer_t;

  function automatic logic [6:0] lctf_sat_level(input logic [6:0] level);
    lctf_sat_level = (level > LEVEL_MAX) ? LEVEL_MAX : level;
  endfunction

  // (c*(128-s) + t*s) >> 7, s in 0..100
  function automatic logic [7:0] lctf_mix(input logic [7:0] c, input logic [7:0] t,
                                          input logic [6:0] s);
    logic [7:0]  w;
    logic [15:0] pc;
    logic [15:0] pt;
    logic [15:0] sum;
    w   = BLEND_ONE - {1'b0, s};
    pc  = {8'd0, c} * {8'd0, w};
    pt  = {8'd0, t} * {9'd0, s};
    sum = pc + pt;
    lctf_mix = sum[14:7];
  endfunction

endpackage

@@ rtl/lctf_strength.sv @@
// lctf_strength: first pipeline stage; works out both layer strengths from
// alpha and the level registers, zeroes transparent pixels. Uses lctf_pkg.
module lctf_strength (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  logic [31:0]          pixel_i,
  input  lctf_pkg::lctf_layer_t layer1_i,
  input  lctf_pkg::lctf_layer_t layer2_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output lctf_pkg::lctf_word_t  word_o
);

  logic                 valid_r;
  lctf_pkg::lctf_word_t word_r;
  lctf_pkg::lctf_word_t word_nxt;
  logic [7:0]           alpha;

  function automatic logic [6:0] strength(input logic [7:0] a,
                                          input lctf_pkg::lctf_layer_t l);
    logic [6:0]  sat;
    logic [14:0] prod;
    sat  = lctf_pkg::lctf_sat_level(l.level);
    prod = {7'd0, a} * {8'd0, sat};
    if (!l.enable) begin
      strength = 7'd0;
    end else if (a < lctf_pkg::ALPHA_FULL) begin
      strength = prod[14:8];
    end else begin
      strength = sat;
    end
  endfunction

  assign alpha = pixel_i[31:24];

  always_comb begin
    word_nxt.pixel = (alpha == 8'd0) ? 32'd0 : pixel_i;
    word_nxt.s1    = strength(alpha, layer1_i);
    word_nxt.s2    = strength(alpha, layer2_i);
  end

  assign ready_o = !valid_r || ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      word_r <= word_nxt;
    end
  end

  assign valid_o = valid_r;
  assign word_o  = word_r;

endmodule

@@ rtl/lctf_blend.sv @@
// lctf_blend: one tint layer stage; blends R, G, B toward the tint color and
// registers the result. Uses lctf_pkg.
module lctf_blend (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                valid_i,
  output logic                ready_o,
  input  lctf_pkg::lctf_word_t word_i,
  input  logic [6:0]          strength_i,
  input  logic [23:0]         color_i,
  output logic                valid_o,
  input  logic                ready_i,
  output lctf_pkg::lctf_word_t word_o
);

  logic                 valid_r;
  lctf_pkg::lctf_word_t word_r;
  lctf_pkg::lctf_word_t word_nxt;

  // pixel: R 23:16, G 15:8, B 7:0; color: B 23:16, G 15:8, R 7:0
  always_comb begin
    word_nxt              = word_i;
    word_nxt.pixel[23:16] = lctf_pkg::lctf_mix(word_i.pixel[23:16], color_i[7:0],
                                               strength_i);
    word_nxt.pixel[15:8]  = lctf_pkg::lctf_mix(word_i.pixel[15:8], color_i[15:8],
                                               strength_i);
    word_nxt.pixel[7:0]   = lctf_pkg::lctf_mix(word_i.pixel[7:0], color_i[23:16],
                                               strength_i);
  end

  assign ready_o = !valid_r || ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      word_r <= word_nxt;
    end
  end

  assign valid_o = valid_r;
  assign word_o  = word_r;

endmodule

@@ rtl/layered_color_tint_filter.sv @@
// layered_color_tint_filter: top level; APB register file plus a three-stage
// pixel pipeline (strength, first layer, second layer). Uses lctf_pkg,
// lctf_strength and lctf_blend.
// Pipeline: 3 register stages (strength, first blend, second blend); an accepted
// word passes through them in that order, and the third drives out_tvalid.
// Throughput: one word per clock unless the output stalls; each stage holds
// one word and moves on as soon as the next stage frees up, so a stalled
// output only halts the stages that are full.
// Reset (synchronous, rst_n low): register file to 0, pipeline emptied.
module layered_color_tint_filter (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] pixel_in
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] pixel_out
  // APB register port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lctf_pkg::AddrW-1:0]   paddr,
  input  logic [lctf_pkg::DataW-1:0]   pwdata,
  output logic [lctf_pkg::DataW-1:0]   prdata,
  output logic                         pready
);

  // ---------------------------------------------------------------------
  // Register file. Index is the word address paddr[4:2]; indexes 6 and 7
  // are ignored on write and read back as zero.
  // ---------------------------------------------------------------------
  lctf_pkg::lctf_layer_t layer1_r;
  lctf_pkg::lctf_layer_t layer2_r;
  logic                  wr_en;
  logic [2:0]            reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      layer1_r <= '0;
      layer2_r <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        lctf_pkg::REG_FIRST_ENABLE:  layer1_r.enable <= pwdata[0];
        lctf_pkg::REG_FIRST_COLOR:   layer1_r.color  <= pwdata[23:0];
        lctf_pkg::REG_FIRST_LEVEL:   layer1_r.level  <= pwdata[6:0];
        lctf_pkg::REG_SECOND_ENABLE: layer2_r.enable <= pwdata[0];
        lctf_pkg::REG_SECOND_COLOR:  layer2_r.color  <= pwdata[23:0];
        lctf_pkg::REG_SECOND_LEVEL:  layer2_r.level  <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      lctf_pkg::REG_FIRST_ENABLE:  prdata = {31'd0, layer1_r.enable};
      lctf_pkg::REG_FIRST_COLOR:   prdata = {8'd0, layer1_r.color};
      lctf_pkg::REG_FIRST_LEVEL:   prdata = {25'd0, layer1_r.level};
      lctf_pkg::REG_SECOND_ENABLE: prdata = {31'd0, layer2_r.enable};
      lctf_pkg::REG_SECOND_COLOR:  prdata = {8'd0, layer2_r.color};
      lctf_pkg::REG_SECOND_LEVEL:  prdata = {25'd0, layer2_r.level};
      default:                     prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Pixel pipeline.
  // Stage 1: strengths s = level (clamped to 100), scaled by alpha/256
  //          below alpha 250; a disabled layer gets s = 0, which blends
  //          to the identity. Alpha zero clears the whole word here, and
  //          the zero pixel then stays zero through both blends.
  // Stage 2: first layer blend.
  // Stage 3: second layer blend; this register is the output register.
  // ---------------------------------------------------------------------
  logic                 v1, v2, v3;
  logic                 rdy2, rdy3;
  lctf_pkg::lctf_word_t w1, w2, w3;

  lctf_strength u_strength (
    .clk      (clk),
    .rst_n    (rst_n),
    .valid_i  (in_tvalid),
    .ready_o  (in_tready),
    .pixel_i  (in_tdata),
    .layer1_i (layer1_r),
    .layer2_i (layer2_r),
    .valid_o  (v1),
    .ready_i  (rdy2),
    .word_o   (w1)
  );

  lctf_blend u_blend1 (
    .clk        (clk),
    .rst_n      (rst_n),
    .valid_i    (v1),
    .ready_o    (rdy2),
    .word_i     (w1),
    .strength_i (w1.s1),
    .color_i    (layer1_r.color),
    .valid_o    (v2),
    .ready_i    (rdy3),
    .word_o     (w2)
  );

  lctf_blend u_blend2 (
    .clk        (clk),
    .rst_n      (rst_n),
    .valid_i    (v2),
    .ready_o    (rdy3),
    .word_i     (w2),
    .strength_i (w2.s2),
    .color_i    (layer2_r.color),
    .valid_o    (v3),
    .ready_i    (out_tready),
    .word_o     (w3)
  );

  assign out_tvalid = v3;
  assign out_tdata  = w3.pixel;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // transparent input leaves as an all-zero word
  a_zero_alpha: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[31:24] == 8'd0) |-> out_tdata == 32'd0)
    else $error("nonzero result for zero alpha");

  // strengths never exceed the clamp
  a_strength_range: assert property (@(posedge clk) disable iff (!rst_n)
    v1 |-> (w1.s1 <= lctf_pkg::LEVEL_MAX) && (w1.s2 <= lctf_pkg::LEVEL_MAX))
    else $error("strength above clamp");

  // input only backs up when the output stage is full and stalled
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled with room in pipeline");

  // a register write lands in the register file
  a_level_write: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en && (reg_idx == lctf_pkg::REG_FIRST_LEVEL) |=>
      layer1_r.level == $past(pwdata[6:0]))
    else $error("first level write lost");

endmodule

@@ dv/tb_top.sv @@
// tb_top: self-checking bench for layered_color_tint_filter. Drives pixel words
// and APB register writes, predicts each tinted pixel and checks the stream.
// Depends on rtl/lctf_pkg.sv and rtl/layered_color_tint_filter.sv.
`timescale 1ns / 100ps

module tb_top;

  // indexes past the register list: writes there must be dropped
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  localparam logic [2:0] R_FE = lctf_pkg::REG_FIRST_ENABLE;
  localparam logic [2:0] R_FC = lctf_pkg::REG_FIRST_COLOR;
  localparam logic [2:0] R_FL = lctf_pkg::REG_FIRST_LEVEL;
  localparam logic [2:0] R_SE = lctf_pkg::REG_SECOND_ENABLE;
  localparam logic [2:0] R_SC = lctf_pkg::REG_SECOND_COLOR;
  localparam logic [2:0] R_SL = lctf_pkg::REG_SECOND_LEVEL;

  localparam int NUM_SETTINGS     = 8;
  localparam int WORDS_PER_SETTING = 240;
  localparam int TAIL_CYCLES      = 12;   // pipeline is 3 deep, plus slack

  // directed table: a row is either a pixel word or a register write
  typedef enum logic {ROW_PIXEL, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [2:0]  reg_idx;   // ROW_REG only
    logic [31:0] value;     // pixel word or register value
    logic        typed;     // 1: use want, 0: use the predictor
    logic [31:0] want;
  } tint_row_t;

  localparam int NUM_ROWS = 33;
  localparam tint_row_t DIRECTED [NUM_ROWS] = '{
    // out of reset both layers are off: zero alpha clears, anything else passes
    '{ROW_PIXEL, R_FE, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{ROW_PIXEL, R_FE, 32'h00FF_FFFF, 1'b1, 32'h0000_0000},
    '{ROW_PIXEL, R_FE, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
    '{ROW_PIXEL, R_FE, 32'h0100_0000, 1'b1, 32'h0100_0000},
    '{ROW_PIXEL, R_FE, 32'h7F5A_3C96, 1'b1, 32'h7F5A_3C96},
    // first layer on; oversized values keep their low bits, level 127 saturates
    '{ROW_REG,   R_FE,         32'hFFFF_FFFF, 1'b0, 32'h0},
    '{ROW_REG,   R_FC,         32'hFF00_80FF, 1'b0, 32'h0},
    '{ROW_REG,   R_FL,         32'hFFFF_FFFF, 1'b0, 32'h0},
    '{ROW_REG,   REG_SPARE_LO, 32'h1234_5678, 1'b0, 32'h0},
    '{ROW_REG,   REG_SPARE_HI, 32'hFFFF_FFFF, 1'b0, 32'h0},
    '{ROW_PIXEL, R_FE, 32'hFF00_0000, 1'b0, 32'h0},
    '{ROW_PIXEL, R_FE, 32'hFFFF_FFFF, 1'b0, 32'h0},
    '{ROW_PIXEL, R_FE, 32'hFA12_3456, 1'b0, 32'h0},  // alpha at threshold
    '{ROW_PIXEL, R_FE, 32'hF912_3456, 1'b0, 32'h0},  // just below
    '{ROW_PIXEL, R_FE, 32'h01FF_FFFF, 1'b0, 32'h0},
    '{ROW_PIXEL, R_FE, 32'h0012_3456, 1'b1, 32'h0000_0000},
    // second layer stacked on the first
    '{ROW_REG,   R_SE, 32'h0000_0001, 1'b0, 32'h0},
    '{ROW_REG,   R_SC, 32'h00FF_FF00, 1'b0, 32'h0},
    '{ROW_REG,   R_SL, 32'h0000_0064, 1'b0, 32'h0},
    '{ROW_PIXEL, R_FE, 32'hFF00_FF00, 1'b0, 32'h0},
    '{ROW_PIXEL, R_FE, 32'h8080_8080, 1'b0, 32'h0},
    '{ROW_PIXEL, R_FE, 32'hFF00_00FF, 1'b0, 32'h0},
    '{ROW_PIXEL, R_FE, 32'hC0FF_FFFF, 1'b0, 32'h0},
    // first level zero, second just over range
    '{ROW_REG,   R_FL, 32'h0000_0000, 1'b0, 32'h0},
    '{ROW_REG,   R_SL, 32'h0000_0065, 1'b0, 32'h0},
    '{ROW_PIXEL, R_FE, 32'hFF40_80C0, 1'b0, 32'h0},
    '{ROW_PIXEL, R_FE, 32'h40FF_00FF, 1'b0, 32'h0},
    // second layer alone
    '{ROW_REG,   R_FE, 32'h0000_0000, 1'b0, 32'h0},
    '{ROW_PIXEL, R_FE, 32'hFFFF_FFFF, 1'b0, 32'h0},
    '{ROW_PIXEL, R_FE, 32'hFE01_0203, 1'b0, 32'h0},
    // both off again: pass-through
    '{ROW_REG,   R_SE, 32'h0000_0000, 1'b0, 32'h0},
    '{ROW_PIXEL, R_FE, 32'h9CAB_CDEF, 1'b1, 32'h9CAB_CDEF},
    '{ROW_PIXEL, R_FE, 32'h00AB_CDEF, 1'b1, 32'h0000_0000}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;     // [31:0] pixel_in
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;         // [31:0] pixel_out
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // bench copy of the two tint layers, updated at each register write edge
  lctf_pkg::lctf_layer_t tint_cfg [2] = '{default: '0};

  logic [31:0] tint_expected [$];  // predicted pixel_out words, oldest first

  int fails = 0;
  int words_sent = 0;
  int directed_words = 0;
  int results_checked = 0;
  int settings_applied = 0;
  int gap_odds = 0;     // percent chance of a sender gap before a word
  int stall_odds = 0;   // percent chance of a receiver stall burst
  int stall_left = 0;

  layered_color_tint_filter u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #5 clk = ~clk;

  // hard stop in case the handshakes hang
  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  // layer strength: level clamped to 100, scaled by alpha below the threshold
  function automatic int unsigned layer_strength(logic [7:0] alpha, logic [6:0] level);
    int unsigned s;
    s = 32'((level > lctf_pkg::LEVEL_MAX) ? lctf_pkg::LEVEL_MAX : level);
    if (alpha < lctf_pkg::ALPHA_FULL) s = (alpha * s) >> 8;
    return s;
  endfunction

  function automatic logic [7:0] blend_byte(logic [7:0] c, logic [7:0] t, int unsigned s);
    int unsigned acc;
    acc = c * (lctf_pkg::BLEND_ONE - s) + t * s;
    return 8'(acc >> 7);
  endfunction

  // tint color bytes: red 7:0, green 15:8, blue 23:16 (reverse of the pixel)
  function automatic logic [31:0] tinted_pixel(logic [31:0] px);
    logic [7:0] alpha;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    int unsigned s;
    alpha = px[31:24];
    if (alpha == 8'd0) return '0;
    r = px[23:16];
    g = px[15:8];
    b = px[7:0];
    for (int k = 0; k < 2; k++) begin
      if (tint_cfg[k].enable) begin
        s = layer_strength(alpha, tint_cfg[k].level);
        r = blend_byte(r, tint_cfg[k].color[7:0], s);
        g = blend_byte(g, tint_cfg[k].color[15:8], s);
        b = blend_byte(b, tint_cfg[k].color[23:16], s);
      end
    end
    return {alpha, r, g, b};
  endfunction

  // ---------------------------------------------------------------- drivers

  // APB write: setup then access; the register takes it at the access edge
  task automatic cfg_write(logic [2:0] idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      lctf_pkg::REG_FIRST_ENABLE:  tint_cfg[0].enable = value[0];
      lctf_pkg::REG_FIRST_COLOR:   tint_cfg[0].color  = value[23:0];
      lctf_pkg::REG_FIRST_LEVEL:   tint_cfg[0].level  = value[6:0];
      lctf_pkg::REG_SECOND_ENABLE: tint_cfg[1].enable = value[0];
      lctf_pkg::REG_SECOND_COLOR:  tint_cfg[1].color  = value[23:0];
      lctf_pkg::REG_SECOND_LEVEL:  tint_cfg[1].level  = value[6:0];
      default: ;  // spare index, nothing latched
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // one pixel word, with an optional random gap first; called at a falling edge
  // and returns at one. tvalid stays high between back-to-back words.
  task automatic send_word(logic [31:0] px, logic typed, logic [31:0] want);
    if ($urandom_range(0, 99) < gap_odds) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= px;
    do @(posedge clk); while (!in_tready);
    tint_expected.push_back(typed ? want : tinted_pixel(px));
    words_sent++;
    @(negedge clk);
  endtask

  // hold off the sender until every predicted word has come back
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (tint_expected.size() != 0);
  endtask

  // one register setting per random stretch; the first few are the corners
  task automatic program_setting(int idx);
    logic [31:0] en_a;
    logic [31:0] en_b;
    logic [31:0] col_a;
    logic [31:0] col_b;
    logic [31:0] lvl_a;
    logic [31:0] lvl_b;
    en_a  = $urandom();
    en_b  = $urandom();
    col_a = $urandom();
    col_b = $urandom();
    lvl_a = ($urandom() & 32'hFFFF_FF80) | $urandom_range(0, 127);
    lvl_b = ($urandom() & 32'hFFFF_FF80) | $urandom_range(0, 127);
    case (idx)
      0: begin  // full strength toward white then black
        en_a = 1; en_b = 1; col_a = 32'h00FF_FFFF; col_b = 32'h0; lvl_a = 100; lvl_b = 100;
      end
      1: begin  // saturating level and a zero level
        en_a = 1; en_b = 1; lvl_a = 127; lvl_b = 0;
      end
      2: en_b = 0;
      3: en_a = 0;
      4: begin en_a = 0; en_b = 0; end
      default: ;
    endcase
    cfg_write(lctf_pkg::REG_FIRST_ENABLE,  en_a);
    cfg_write(lctf_pkg::REG_FIRST_COLOR,   col_a);
    cfg_write(lctf_pkg::REG_FIRST_LEVEL,   lvl_a);
    cfg_write(lctf_pkg::REG_SECOND_ENABLE, en_b);
    cfg_write(lctf_pkg::REG_SECOND_COLOR,  col_b);
    cfg_write(lctf_pkg::REG_SECOND_LEVEL,  lvl_b);
    if ($urandom_range(0, 1)) cfg_write(REG_SPARE_LO, $urandom());
    if ($urandom_range(0, 1)) cfg_write(REG_SPARE_HI, $urandom());
    settings_applied++;
  endtask

  // random pixel, leaning on the alpha corners and flat black/white color
  function automatic logic [31:0] random_pixel();
    logic [31:0] px;
    px = $urandom();
    case ($urandom_range(0, 9))
      0: px[31:24] = 8'h00;
      1: px[31:24] = 8'hFF;
      2: px[31:24] = 8'($urandom_range(249, 250));
      3: px[31:24] = 8'($urandom_range(1, 3));
      default: ;
    endcase
    if ($urandom_range(0, 7) == 0) px[23:0] = $urandom_range(0, 1) ? 24'hFF_FFFF : 24'h0;
    return px;
  endfunction

  // receiver: random stall bursts, their odds set by stall_odds
  always @(negedge clk) begin
    if (stall_left == 0 && $urandom_range(0, 99) < stall_odds)
      stall_left = $urandom_range(1, 5);
    if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- checker

  always @(posedge clk) begin : check_out
    logic [31:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (tint_expected.size() == 0) begin
        $error("pixel_out: unexpected word %h", out_tdata);
        fails++;
      end else begin
        want = tint_expected.pop_front();
        if (out_tdata !== want) begin
          $error("pixel_out mismatch: expected %h, got %h", want, out_tdata);
          fails++;
        end
        results_checked++;
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    int pause_at;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table; register rows wait for the pipe to empty first
    gap_odds   = 20;
    stall_odds = 20;
    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].kind == ROW_REG) begin
        drain();
        cfg_write(DIRECTED[i].reg_idx, DIRECTED[i].value);
      end else begin
        send_word(DIRECTED[i].value, DIRECTED[i].typed, DIRECTED[i].want);
      end
    end
    directed_words = words_sent;

    // random stretches, each under its own setting; idle pressure cycles
    // through none / light / heavy, and the last stretch runs flat out
    for (int p = 0; p < NUM_SETTINGS; p++) begin
      drain();
      program_setting(p);
      if (p == NUM_SETTINGS - 1) begin
        gap_odds   = 0;
        stall_odds = 0;
      end else begin
        gap_odds   = (p % 3) * 20;
        stall_odds = ((p + 1) % 3) * 20;
      end
      pause_at = $urandom_range(20, WORDS_PER_SETTING - 20);
      for (int n = 0; n < WORDS_PER_SETTING; n++) begin
        if (n == pause_at && p != NUM_SETTINGS - 1) drain();
        send_word(random_pixel(), 1'b0, '0);
      end
    end
    in_tvalid <= 1'b0;

    while (tint_expected.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Ran %0d directed and %0d random pixel words under %0d register settings,",
             directed_words, words_sent - directed_words, settings_applied);
    $display("with sender gaps and receiver stalls; %0d results checked, %0d mismatches.",
             results_checked, fails);
    if (fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/lctf_pkg.sv
rtl/lctf_strength.sv
rtl/lctf_blend.sv
rtl/layered_color_tint_filter.sv
dv/tb_top.sv
